// ----- src/assert_macros.svh -----
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/pwfp_pkg.sv -----
// types, constants and frame helpers for the pulse width frame programmer
package pwfp_pkg;

    localparam int TICK_COUNT_WIDTH = 8;
    localparam int CFG_W            = 8;
    localparam int FRAME_LEN        = 38;
    localparam int POS_W            = 6;
    localparam int LEN_W            = (TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W;

    localparam logic [11:0] START_BITS = 12'b100000000001;
    localparam logic [11:0] END_BITS   = 12'b011111111110;
    localparam logic [TICK_COUNT_WIDTH-1:0] CNT_MAX = '1;

    localparam logic [7:0] RST_ZERO_HIGH = 8'd2;
    localparam logic [7:0] RST_ONE_HIGH  = 8'd60;
    localparam logic [7:0] RST_GAP_LOW   = 8'd20;
    localparam logic [1:0] RST_DUMMY     = 2'd2;

    typedef logic [TICK_COUNT_WIDTH-1:0] t_ticks;
    typedef logic [FRAME_LEN-1:0]        t_frame;

    typedef enum logic [1:0] {
        CFG_ZERO_HIGH = 2'd0,
        CFG_ONE_HIGH  = 2'd1,
        CFG_GAP_LOW   = 2'd2,
        CFG_DUMMY     = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        KIND_TICK    = 1'b0,
        KIND_COMMAND = 1'b1
    } t_kind;

    typedef struct packed {
        logic [CFG_W-1:0] zero_high;
        logic [CFG_W-1:0] one_high;
        logic [CFG_W-1:0] gap_low;
        logic [1:0]       dummy;
    } t_cfg;

    typedef struct packed {
        logic line;
        logic busy;
        logic done;
        logic rejected;
    } t_result;

    // zero acts as one tick, lengths beyond the counter range saturate
    function automatic t_ticks clamp_len(logic [CFG_W-1:0] v);
        logic [LEN_W-1:0] ext;
        ext = LEN_W'(v);
        if (ext > LEN_W'(CNT_MAX)) ext = LEN_W'(CNT_MAX);
        if (ext == '0) ext = LEN_W'(1);
        return TICK_COUNT_WIDTH'(ext);
    endfunction

    // bit 0 of the result goes out first
    function automatic t_frame build_frame(logic [1:0] fc, logic [1:0] pc,
                                           logic [1:0] dummy, logic [7:0] val);
        logic [7:0] rev;
        for (int i = 0; i < 8; i++) rev[i] = val[7-i];
        return {END_BITS, rev, fc, pc, dummy, START_BITS};
    endfunction

endpackage

// ----- src/pwfp_sequencer.sv -----
// frame state and per-word bit timing of the pulse width frame programmer
module pwfp_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_kind,
    input  logic [1:0]       i_function_code,
    input  logic [1:0]       i_parameter_code,
    input  logic [7:0]       i_value,
    input  pwfp_pkg::t_cfg    i_cfg,
    output pwfp_pkg::t_result o_res
);
    import pwfp_pkg::*;

    t_frame           r_frame, n_frame;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_in_gap, n_in_gap;
    t_ticks           r_phase, n_phase;
    logic             r_sending, n_sending;
    t_ticks           w_len;
    t_result          w_res;

    always_comb begin
        n_frame   = r_frame;
        n_pos     = r_pos;
        n_in_gap  = r_in_gap;
        n_phase   = r_phase;
        n_sending = r_sending;
        w_res     = '0;
        if (r_in_gap) begin
            w_len = clamp_len(i_cfg.gap_low);
        end else begin
            w_len = clamp_len(r_frame[0] ? i_cfg.one_high : i_cfg.zero_high);
        end
        if (i_step) begin
            if (i_kind == KIND_COMMAND) begin
                if (r_sending) begin
                    w_res.rejected = 1'b1;
                end else begin
                    n_frame   = build_frame(i_function_code, i_parameter_code,
                                            i_cfg.dummy, i_value);
                    n_pos     = '0;
                    n_in_gap  = 1'b0;
                    n_phase   = '0;
                    n_sending = 1'b1;
                end
            end else if (r_sending) begin
                w_res.line = !r_in_gap;
                n_phase    = r_phase + t_ticks'(1);
                if (n_phase >= w_len) begin
                    n_phase = '0;
                    if (!r_in_gap) begin
                        n_in_gap = 1'b1;
                    end else begin
                        // gap over: move on to the next bit
                        n_in_gap = 1'b0;
                        n_frame  = {1'b0, r_frame[FRAME_LEN-1:1]};
                        n_pos    = r_pos + POS_W'(1);
                        if (n_pos >= POS_W'(FRAME_LEN)) begin
                            n_sending  = 1'b0;
                            n_pos      = '0;
                            w_res.done = 1'b1;
                        end
                    end
                end
            end
        end
        w_res.busy = n_sending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame   <= '0;
            r_pos     <= '0;
            r_in_gap  <= 1'b0;
            r_phase   <= '0;
            r_sending <= 1'b0;
        end else begin
            r_frame   <= n_frame;
            r_pos     <= n_pos;
            r_in_gap  <= n_in_gap;
            r_phase   <= n_phase;
            r_sending <= n_sending;
        end
    end

    assign o_res = w_res;

endmodule

// ----- src/pulse_width_frame_programmer_unit.sv -----
// Single-wire pulse width frame programmer. A command word loads a 38-bit
// frame (start bits, function/parameter/dummy field, value MSB first, end
// bits); tick words then drive the line, high for the zero or one length of
// each bit and low for the gap length. Every input word yields one result
// word; a word can be accepted in every cycle while o_stall is low, and
// an output register with a skid stage behind it lets the input side keep
// accepting while one result waits; o_stall rises only once the skid stage
// is full. Configuration writes take effect on the next word.
`include "assert_macros.svh"

module pulse_width_frame_programmer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [1:0] i_function_code,
    input  logic [1:0] i_parameter_code,
    input  logic [7:0] i_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_line_out,
    output logic       o_busy_res,
    output logic       o_frame_done,
    output logic       o_rejected
);
    import pwfp_pkg::*;

    t_cfg    r_cfg;
    t_result r_out, r_skid, w_res;
    logic    r_out_valid, r_skid_valid;
    logic    w_accept, w_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high <= RST_ZERO_HIGH;
            r_cfg.one_high  <= RST_ONE_HIGH;
            r_cfg.gap_low   <= RST_GAP_LOW;
            r_cfg.dummy     <= RST_DUMMY;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_data;
                CFG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_data;
                CFG_GAP_LOW:   r_cfg.gap_low   <= i_cfg_data;
                CFG_DUMMY:     r_cfg.dummy     <= i_cfg_data[1:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign o_stall  = r_skid_valid;
    assign w_accept = i_valid && !r_skid_valid;
    assign w_taken  = r_out_valid && !i_stall;

    pwfp_sequencer u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_accept),
        .i_kind           (i_kind),
        .i_function_code  (i_function_code),
        .i_parameter_code (i_parameter_code),
        .i_value          (i_value),
        .i_cfg            (r_cfg),
        .o_res            (w_res)
    );

    // output word register with a skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_taken) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (w_accept) begin
                if (r_out_valid && !w_taken) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (w_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_taken) r_out <= r_skid;
        end else if (w_accept) begin
            if (r_out_valid && !w_taken) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_line_out   = r_out.line;
    assign o_busy_res   = r_out.busy;
    assign o_frame_done = r_out.done;
    assign o_rejected   = r_out.rejected;

    `ASSERT_ALWAYS(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid, "skid word without output word")
    `ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, w_accept, r_out_valid, "accepted word did not reach output")
    `ASSERT_ALWAYS(a_reject_only_busy, i_clk, i_rst_n, !(w_accept && w_res.rejected) || w_res.busy, "reject while idle")

endmodule
